@@ rtl/core/tcrc_pkg.sv @@
package tcrc_pkg;

  localparam logic [16:0] FULL = 17'd65536;

  localparam logic [1:0] OP_IDLE  = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [2:0] PH_TILT_MOVING  = 3'd0;
  localparam logic [2:0] PH_TILT_WAIT    = 3'd1;
  localparam logic [2:0] PH_TILT_STOPPED = 3'd2;
  localparam logic [2:0] PH_MOVING       = 3'd3;
  localparam logic [2:0] PH_MOVE_WAIT    = 3'd4;
  localparam logic [2:0] PH_ENDSTOP      = 3'd5;
  localparam logic [2:0] PH_STOPPED      = 3'd6;

  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_STOP = 3'd1;
  localparam logic [2:0] REQ_POS  = 3'd2;
  localparam logic [2:0] REQ_TILT = 3'd3;
  localparam logic [2:0] REQ_TOGG = 3'd4;

  localparam logic [2:0] REG_OPEN_TRAVEL  = 3'd0;
  localparam logic [2:0] REG_CLOSE_TRAVEL = 3'd1;
  localparam logic [2:0] REG_TILT_OPEN    = 3'd2;
  localparam logic [2:0] REG_TILT_CLOSE   = 3'd3;
  localparam logic [2:0] REG_EXTRA_WAIT   = 3'd4;
  localparam logic [2:0] REG_ENDSTOP_WAIT = 3'd5;
  localparam logic [2:0] REG_CTRL_DIS     = 3'd6;

  // divider command from controller to datapath
  typedef struct packed {
    logic start;
    logic [31:0] elapsed;
    logic [19:0] dur;
    logic tilt;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic [47:0] quot;
  } div_sts_t;

endpackage

@@ rtl/core/timed_cover_relay_controller.sv @@
// Relay controller for a tilting-slat blind. A tick that updates the travel
// estimate goes through the accept cycle, the divide state (launch, 48
// restoring steps, done check), a commit cycle, and the load and hand-off of
// the output register. Commands, and ticks with no travel update, pass the
// divide state without the restoring steps. The result is placed in an output
// register that holds while m_tready is low; the next item is accepted only once
// the sequencer is idle and that register is empty. Config writes are taken any
// time and must only occur while idle.
module timed_cover_relay_controller
  import tcrc_pkg::*;
#(
  parameter int RELAY_DEAD_MS = 500,
  parameter int MAX_RELAY_ON_MS = 120000,
  parameter int REPORT_PERIOD_MS = 1000
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,   // target_value[16:0], zero fill
  input  logic [2:0] s_tuser,    // req_type
  output logic m_tvalid,
  input  logic m_tready,
  output logic [47:0] m_tdata,   // open_relay, close_relay, position_now[16:0],
                                 // tilt_now[16:0], operation[1:0], motion_phase[2:0],
                                 // zero fill
  output logic m_tuser,          // report
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [19:0] cfg_data
);
  logic [19:0] open_travel_ms, close_travel_ms, tilt_open_ms, tilt_close_ms;
  logic [19:0] extra_wait_ms, endstop_wait_ms;
  logic controls_disabled;
  div_cmd_t dcmd;
  div_sts_t dsts;
  logic clr_pos, clr_tilt, busy, res_valid, in_fire, rep;
  logic [1:0] rb, opv;
  logic [16:0] pos, tlt;
  logic [2:0] ph;
  logic out_full;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      open_travel_ms <= '0; close_travel_ms <= '0; tilt_open_ms <= '0;
      tilt_close_ms <= '0; extra_wait_ms <= '0; endstop_wait_ms <= '0;
      controls_disabled <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OPEN_TRAVEL:  open_travel_ms <= cfg_data;
        REG_CLOSE_TRAVEL: close_travel_ms <= cfg_data;
        REG_TILT_OPEN:    tilt_open_ms <= cfg_data;
        REG_TILT_CLOSE:   tilt_close_ms <= cfg_data;
        REG_EXTRA_WAIT:   extra_wait_ms <= cfg_data;
        REG_ENDSTOP_WAIT: endstop_wait_ms <= cfg_data;
        REG_CTRL_DIS:     controls_disabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready = !busy && !out_full && !res_valid;
  assign in_fire = s_tvalid && s_tready;

  tcrc_ctrl #(
    .RELAY_DEAD_MS(RELAY_DEAD_MS),
    .MAX_RELAY_ON_MS(MAX_RELAY_ON_MS),
    .REPORT_PERIOD_MS(REPORT_PERIOD_MS)
  ) u_ctrl (
    .clk, .rst, .in_fire,
    .req_type(s_tuser), .target_value(s_tdata[16:0]),
    .open_travel_ms, .close_travel_ms, .tilt_open_ms, .tilt_close_ms,
    .extra_wait_ms, .endstop_wait_ms, .controls_disabled,
    .dsts, .dcmd, .clr_pos, .clr_tilt, .busy, .res_valid,
    .relay_bits_o(rb), .position_o(pos), .tilt_o(tlt), .operation_o(opv),
    .phase_o(ph), .report_o(rep)
  );

  tcrc_div u_div (.clk, .rst, .cmd(dcmd), .clr_pos, .clr_tilt, .sts(dsts));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else begin
      if (res_valid) begin
        out_full <= 1'b1;
        m_tdata <= {7'd0, ph, opv, tlt, pos, rb[1], rb[0]};
        m_tuser <= rep;
      end else if (m_tvalid && m_tready) begin
        out_full <= 1'b0;
      end
    end
  end
  assign m_tvalid = out_full;
endmodule

@@ rtl/core/tcrc_div.sv @@
// restoring divider: (elapsed*65536 + rem) / dur, one quotient bit per cycle
module tcrc_div
  import tcrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  div_cmd_t cmd,
  input  logic clr_pos,
  input  logic clr_tilt,
  output div_sts_t sts
);
  logic [47:0] num;
  logic [47:0] quot;
  logic [20:0] rem_acc;
  logic [19:0] dur;
  logic [5:0] cnt;
  logic busy;
  logic tilt_sel;
  logic [19:0] pos_rem, tilt_rem;
  logic [20:0] trial;
  logic [47:0] num_init;

  assign trial = {rem_acc[19:0], num[47]};
  assign num_init = {cmd.elapsed, 16'd0} + {28'd0, (cmd.tilt ? tilt_rem : pos_rem)};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      pos_rem <= '0;
      tilt_rem <= '0;
    end else begin
      if (cmd.start) begin
        busy <= 1'b1;
        cnt <= 6'd48;
        num <= num_init;
        rem_acc <= '0;
        quot <= '0;
        dur <= cmd.dur;
        tilt_sel <= cmd.tilt;
      end else if (busy) begin
        num <= {num[46:0], 1'b0};
        if (trial >= {1'b0, dur}) begin
          rem_acc <= trial - {1'b0, dur};
          quot <= {quot[46:0], 1'b1};
        end else begin
          rem_acc <= trial;
          quot <= {quot[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) busy <= 1'b0;
      end
      // remainder stored when division finishes
      if (busy && cnt == 6'd1) begin
        if (tilt_sel) tilt_rem <= (trial >= {1'b0, dur}) ? 20'(trial - {1'b0, dur})
                                                          : trial[19:0];
        else pos_rem <= (trial >= {1'b0, dur}) ? 20'(trial - {1'b0, dur}) : trial[19:0];
      end
      if (clr_pos) pos_rem <= '0;
      if (clr_tilt) tilt_rem <= '0;
    end
  end

  assign sts.busy = busy | cmd.start;
  assign sts.quot = quot;
endmodule

@@ rtl/core/tcrc_ctrl.sv @@
// sequencer: decodes an item, runs the divider when needed, applies the model
module tcrc_ctrl
  import tcrc_pkg::*;
#(
  parameter int RELAY_DEAD_MS = 500,
  parameter int MAX_RELAY_ON_MS = 120000,
  parameter int REPORT_PERIOD_MS = 1000
) (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic [2:0] req_type,
  input  logic [16:0] target_value,
  input  logic [19:0] open_travel_ms,
  input  logic [19:0] close_travel_ms,
  input  logic [19:0] tilt_open_ms,
  input  logic [19:0] tilt_close_ms,
  input  logic [19:0] extra_wait_ms,
  input  logic [19:0] endstop_wait_ms,
  input  logic controls_disabled,
  input  div_sts_t dsts,
  output div_cmd_t dcmd,
  output logic clr_pos,
  output logic clr_tilt,
  output logic busy,
  output logic res_valid,
  output logic [1:0] relay_bits_o,
  output logic [16:0] position_o,
  output logic [16:0] tilt_o,
  output logic [1:0] operation_o,
  output logic [2:0] phase_o,
  output logic report_o
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic [2:0] rtype;
  logic [16:0] tv;

  logic [31:0] ms_clock, move_start_ms, phase_time_ms, relay_change_ms;
  logic [31:0] last_update_ms, last_report_ms;
  logic [16:0] cur_position, cur_tilt, goal_position, goal_tilt;
  logic [1:0] cur_operation, prev_operation, waiting_operation, relay_bits;
  logic [2:0] phase;

  // working copies for the combinational update
  logic [31:0] n_ms, n_ms_start, n_ph_t, n_rc, n_lu, n_lr;
  logic [16:0] n_pos, n_tilt, n_gp, n_gt;
  logic [1:0] n_cop, n_pop, n_wop, n_rb;
  logic [2:0] n_ph;
  logic n_rep, n_cpos, n_ctilt;
  logic need_div, div_tilt, div_up;
  logic [19:0] div_dur;
  logic [31:0] div_el;
  logic [16:0] div_v;
  logic rep;

  logic [31:0] now, el;
  logic tracking;

  assign tracking = (open_travel_ms != 20'd0) && (close_travel_ms != 20'd0);

  // saturating apply of the quotient
  function automatic logic [16:0] apply_q(input logic [16:0] v, input logic [47:0] d,
                                          input logic up);
    logic [47:0] room;
    begin
      room = up ? 48'(FULL - v) : 48'(v);
      if (d >= room) apply_q = up ? FULL : 17'd0;
      else apply_q = up ? 17'(v + d[16:0]) : 17'(v - d[16:0]);
    end
  endfunction

  function automatic logic sat_q(input logic [16:0] v, input logic [47:0] d, input logic up);
    sat_q = up ? (d >= 48'(FULL - v)) : (d >= 48'(v));
  endfunction

  always_comb begin
    logic go;
    logic [1:0] op, other;
    logic is_tick;
    n_ms = ms_clock; n_ms_start = move_start_ms; n_ph_t = phase_time_ms;
    n_rc = relay_change_ms; n_lu = last_update_ms; n_lr = last_report_ms;
    n_pos = cur_position; n_tilt = cur_tilt; n_gp = goal_position; n_gt = goal_tilt;
    n_cop = cur_operation; n_pop = prev_operation; n_wop = waiting_operation;
    n_rb = relay_bits; n_ph = phase; n_rep = 1'b0; n_cpos = 1'b0; n_ctilt = 1'b0;
    need_div = 1'b0; div_tilt = 1'b0; div_up = 1'b0; div_dur = '0; div_v = '0;
    go = 1'b0; op = OP_IDLE; other = OP_IDLE;
    is_tick = (rtype == REQ_TICK);
    now = ms_clock + (is_tick ? 32'd1 : 32'd0);
    el = now - last_update_ms;
    div_el = el;

    if (is_tick) begin
      n_ms = now;
      if (cur_operation != OP_IDLE) begin
        if (tracking) begin
          n_lu = now;
          if (cur_operation == OP_OPEN) begin
            unique case (phase)
              PH_TILT_MOVING: begin
                if (cur_tilt >= goal_tilt) begin
                  n_ph_t = now;
                  if (goal_tilt == FULL)
                    n_ph = (cur_position >= goal_position) ? PH_ENDSTOP : PH_TILT_WAIT;
                  else n_ph = PH_TILT_STOPPED;
                end else if (tilt_open_ms == 20'd0) begin
                  n_tilt = FULL; n_ctilt = 1'b1;
                end else begin
                  need_div = 1'b1; div_tilt = 1'b1; div_up = 1'b1;
                  div_dur = tilt_open_ms; div_v = cur_tilt;
                end
              end
              PH_TILT_WAIT:
                if (now - phase_time_ms > 32'(extra_wait_ms)) begin
                  n_ph = PH_TILT_STOPPED; n_ph_t = now;
                end
              PH_TILT_STOPPED: begin
                n_rb[0] = 1'b0;
                if (cur_position >= goal_position) n_ph = PH_STOPPED;
                else if (now - phase_time_ms > 32'(RELAY_DEAD_MS)) begin
                  n_rb[0] = 1'b1; n_ph = PH_MOVING; n_ph_t = now;
                end
              end
              PH_MOVING: begin
                if (cur_position >= goal_position) begin
                  n_ph_t = now;
                  n_ph = (goal_position == FULL) ? PH_ENDSTOP : PH_STOPPED;
                end else begin
                  need_div = 1'b1; div_up = 1'b1;
                  div_dur = open_travel_ms; div_v = cur_position;
                end
              end
              PH_MOVE_WAIT:
                if (now - phase_time_ms > 32'(extra_wait_ms)) begin
                  n_ph = PH_STOPPED; n_ph_t = now;
                end
              PH_ENDSTOP: begin n_cop = OP_IDLE; n_rep = 1'b1; end
              PH_STOPPED: begin n_rb[0] = 1'b0; n_cop = OP_IDLE; n_rep = 1'b1; end
              default: ;
            endcase
          end else begin
            unique case (phase)
              PH_TILT_MOVING: begin
                if (cur_tilt <= goal_tilt) begin
                  n_ph_t = now;
                  n_ph = (goal_tilt == 17'd0) ? PH_ENDSTOP : PH_TILT_STOPPED;
                end else if (tilt_close_ms == 20'd0) begin
                  n_tilt = 17'd0; n_ctilt = 1'b1;
                end else begin
                  need_div = 1'b1; div_tilt = 1'b1;
                  div_dur = tilt_close_ms; div_v = cur_tilt;
                end
              end
              PH_TILT_WAIT:
                if (now - phase_time_ms > 32'(extra_wait_ms)) begin
                  n_ph = PH_TILT_STOPPED; n_ph_t = now;
                end
              PH_TILT_STOPPED: begin n_rb[1] = 1'b0; n_cop = OP_IDLE; n_rep = 1'b1; end
              PH_MOVING: begin
                if (cur_position <= goal_position) begin
                  n_ph_t = now;
                  if (goal_position == 17'd0)
                    n_ph = (cur_tilt <= goal_tilt) ? PH_ENDSTOP : PH_MOVE_WAIT;
                  else n_ph = PH_STOPPED;
                end else begin
                  need_div = 1'b1;
                  div_dur = close_travel_ms; div_v = cur_position;
                end
              end
              PH_MOVE_WAIT:
                if (now - phase_time_ms > 32'(extra_wait_ms)) begin
                  n_ph = PH_STOPPED; n_ph_t = now;
                end
              PH_ENDSTOP: begin n_cop = OP_IDLE; n_rep = 1'b1; end
              PH_STOPPED: begin
                n_rb[1] = 1'b0;
                if (cur_tilt <= goal_tilt) n_ph = PH_TILT_STOPPED;
                else if (now - phase_time_ms > 32'(RELAY_DEAD_MS)) begin
                  n_rb[1] = 1'b1; n_ph = PH_TILT_MOVING; n_ph_t = now;
                end
              end
              default: ;
            endcase
          end
        end else if (now - move_start_ms > 32'(MAX_RELAY_ON_MS)) begin
          if (cur_operation == OP_OPEN) begin n_pos = FULL; n_rb[0] = 1'b0; end
          else begin n_pos = 17'd0; n_rb[1] = 1'b0; end
          n_cop = OP_IDLE; n_rc = now; n_rep = 1'b1;
        end
        if (now - last_report_ms > 32'(REPORT_PERIOD_MS)) begin
          n_rep = 1'b1; n_lr = now;
        end
      end else if (phase == PH_ENDSTOP && (now - phase_time_ms > 32'(endstop_wait_ms))) begin
        n_ph = PH_STOPPED; n_rb = 2'b00; n_rc = now;
      end
      // pending start retried once the dead time has passed
      if (n_wop != OP_IDLE && (now - n_rc > 32'(RELAY_DEAD_MS))) begin
        go = 1'b1; op = n_wop;
      end
    end else if (!controls_disabled && rtype <= REQ_TOGG) begin
      if (phase == PH_ENDSTOP) begin
        n_rb = 2'b00; n_rc = now; n_ph = PH_STOPPED;
      end
      unique case (rtype)
        REQ_STOP: begin n_gp = cur_position; n_gt = cur_tilt; go = 1'b1; op = OP_IDLE; end
        REQ_POS: begin
          n_gp = tv;
          if (!tracking) begin go = 1'b1; op = (tv == FULL) ? OP_OPEN : OP_CLOSE; end
          else if (cur_tilt != FULL) begin
            n_gt = FULL; n_ph = PH_TILT_MOVING; go = 1'b1; op = OP_OPEN;
          end else if (tv > cur_position) begin
            n_ph = PH_MOVING; go = 1'b1; op = OP_OPEN;
          end else if (tv < cur_position) begin
            n_ph = PH_MOVING; go = 1'b1; op = OP_CLOSE;
          end
        end
        REQ_TILT: begin
          n_gt = tv;
          if (cur_position != 17'd0) begin
            n_gp = 17'd0; go = 1'b1; op = OP_CLOSE; n_ph = PH_MOVING;
          end else if (tv > cur_tilt) begin
            n_ph = PH_TILT_MOVING; go = 1'b1; op = OP_OPEN;
          end else if (tv < cur_tilt) begin
            n_ph = PH_TILT_MOVING; go = 1'b1; op = OP_CLOSE;
          end
        end
        REQ_TOGG: begin
          go = 1'b1;
          if (cur_operation != OP_IDLE) op = OP_IDLE;
          else if (cur_position == 17'd0 || prev_operation == OP_CLOSE) begin
            n_gp = FULL; op = OP_OPEN;
            if (cur_tilt != FULL) begin n_gt = FULL; n_ph = PH_TILT_MOVING; end
            else n_ph = PH_MOVING;
          end else begin
            n_gp = 17'd0;
            if (cur_tilt != FULL) begin
              n_gt = FULL; n_ph = PH_TILT_MOVING; op = OP_OPEN;
            end else begin n_ph = PH_MOVING; op = OP_CLOSE; end
          end
        end
        default: ;
      endcase
    end

    // start of an operation, relay dead time handled here
    if (go && op != n_cop) begin
      if (op == OP_OPEN || op == OP_CLOSE) begin
        other = (op == OP_OPEN) ? OP_CLOSE : OP_OPEN;
        if (n_pop == other) begin
          n_rb = 2'b00; n_wop = op; n_rc = now; n_pop = OP_IDLE;
        end
        if (now - n_rc > 32'(RELAY_DEAD_MS)) begin
          n_rb = n_rb | ((op == OP_OPEN) ? 2'b01 : 2'b10);
          n_wop = OP_IDLE; n_pop = op; n_rc = now; n_ms_start = now;
        end else n_wop = op;
      end else begin
        n_rb = 2'b00; n_wop = OP_IDLE; n_rc = now; n_pop = OP_IDLE;
      end
      if (n_wop == OP_IDLE) begin
        n_cop = op; n_lu = now; n_cpos = 1'b1; n_ctilt = 1'b1; n_rep = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_DIV;
      S_DIV:  if (!dsts.busy) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // divider launched on first cycle of S_DIV when a travel update is due
  logic div_started;
  assign dcmd.start = (state == S_DIV) && need_div && !div_started;
  assign dcmd.elapsed = div_el;
  assign dcmd.dur = div_dur;
  assign dcmd.tilt = div_tilt;
  assign clr_pos = (state == S_DONE) && (n_cpos ||
                   (need_div && !div_tilt && sat_q(div_v, dsts.quot, div_up)));
  assign clr_tilt = (state == S_DONE) && (n_ctilt ||
                    (need_div && div_tilt && sat_q(div_v, dsts.quot, div_up)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      div_started <= 1'b0;
      res_valid <= 1'b0;
      ms_clock <= '0; move_start_ms <= '0; phase_time_ms <= '0; relay_change_ms <= '0;
      last_update_ms <= '0; last_report_ms <= '0;
      cur_position <= 17'd32768; cur_tilt <= FULL; goal_position <= '0; goal_tilt <= '0;
      cur_operation <= OP_IDLE; prev_operation <= OP_IDLE; waiting_operation <= OP_IDLE;
      relay_bits <= 2'b00; phase <= PH_STOPPED; rep <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_fire) begin
        rtype <= req_type;
        tv <= (target_value > FULL) ? FULL : target_value;
        div_started <= 1'b0;
      end
      if (dcmd.start) div_started <= 1'b1;
      if (state == S_DONE) begin
        ms_clock <= n_ms; move_start_ms <= n_ms_start; phase_time_ms <= n_ph_t;
        relay_change_ms <= n_rc; last_update_ms <= n_lu; last_report_ms <= n_lr;
        goal_position <= n_gp; goal_tilt <= n_gt;
        cur_operation <= n_cop; prev_operation <= n_pop; waiting_operation <= n_wop;
        relay_bits <= n_rb; phase <= n_ph; rep <= n_rep;
        if (need_div && div_tilt) cur_tilt <= apply_q(div_v, dsts.quot, div_up);
        else cur_tilt <= n_tilt;
        if (need_div && !div_tilt) cur_position <= apply_q(div_v, dsts.quot, div_up);
        else cur_position <= n_pos;
      end
      res_valid <= (state == S_DONE);
    end
  end

  assign busy = (state != S_IDLE);
  assign relay_bits_o = relay_bits;
  assign position_o = cur_position;
  assign tilt_o = cur_tilt;
  assign operation_o = cur_operation;
  assign phase_o = phase;
  assign report_o = rep;
endmodule
